// File: sv/spmm_pkg.sv
// ----------------------------------------------------------------------------
// Sensor plausibility min/max package
// Beat types, register map, status and action codes and reset values shared
// by the plausibility checker.
// ----------------------------------------------------------------------------
package spmm_pkg;

    localparam int unsigned ValueWidth = 12;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned AddrWidth  = 5;
    localparam int unsigned DataWidth  = 32;

    typedef logic signed [ValueWidth-1:0] value_t;
    typedef logic        [ValueWidth-1:0] jump_t;
    typedef logic        [CountWidth-1:0] count_t;

    // Event codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_READING = 2'd0,
        ACT_FAILED  = 2'd1,
        ACT_RESET   = 2'd2,
        ACT_RESET_B = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_READ_FAIL  = 3'd1,
        ST_TEMP_RANGE = 3'd2,
        ST_HUM_RANGE  = 3'd3,
        ST_TEMP_JUMP  = 3'd4,
        ST_HUM_JUMP   = 3'd5,
        ST_RESET      = 3'd6,
        ST_UNUSED     = 3'd7
    } status_t;

    // Word index of each configuration register (byte address is 4 * index).
    typedef enum logic [2:0] {
        REG_TEMP_LOW  = 3'd0,
        REG_TEMP_HIGH = 3'd1,
        REG_HUM_LOW   = 3'd2,
        REG_HUM_HIGH  = 3'd3,
        REG_TEMP_JUMP = 3'd4,
        REG_HUM_JUMP  = 3'd5,
        REG_FAIL_LIM  = 3'd6,
        REG_NONE      = 3'd7
    } reg_index_t;

    localparam value_t TempLowReset  = -12'sd400;
    localparam value_t TempHighReset = 12'sd1000;
    localparam value_t HumLowReset   = 12'sd0;
    localparam value_t HumHighReset  = 12'sd1000;
    localparam jump_t  TempJumpReset = 12'd100;
    localparam jump_t  HumJumpReset  = 12'd200;
    localparam count_t FailLimReset  = 8'd3;

    localparam value_t MostNeg  = {1'b1, {(ValueWidth-1){1'b0}}};
    localparam value_t MostPos  = {1'b0, {(ValueWidth-1){1'b1}}};
    localparam count_t CountMax = {CountWidth{1'b1}};

    typedef struct packed {
        action_t action;
        value_t  temperature_tenths;
        value_t  humidity_tenths;
    } sample_beat_t;

    typedef struct packed {
        status_t status;
        logic    data_valid;
        value_t  current_temp;
        value_t  current_hum;
        value_t  max_temp;
        value_t  min_temp;
        value_t  max_hum;
        value_t  min_hum;
        count_t  failure_count;
    } result_beat_t;

endpackage

// File: sv/sensor_plausibility_minmax.sv
// ----------------------------------------------------------------------------
// Sensor plausibility check with running minimum and maximum
// Checks temperature/humidity readings against range and jump limits and
// keeps the current values, running extremes and a failure counter.
// ----------------------------------------------------------------------------
// Each input beat is one event: a reading, a failed sensor read or a
// statistics reset. The beat is captured in an input register; when it
// advances, the range and jump checks, the extreme updates and the failure
// counter are evaluated in one pass and the full result is loaded into the
// output register, with the internal state updated at the same edge. Every
// event gives exactly one result beat, which is held in the output register
// until it is taken. A new event can be accepted in every cycle, so sustained
// throughput is one beat per clock; the only limit is the single evaluation
// stage, which stalls only when the output register is full and not being
// drained.
// The limit registers sit on an APB-style port at byte addresses 0 to 24
// and must only be written while no event is in flight. Action code 3 is
// treated as a statistics reset.
module sensor_plausibility_minmax (
    input  logic                        clk,
    input  logic                        rst_n,
    // event input
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  spmm_pkg::sample_beat_t      sample,
    // result output
    output logic                        result_valid,
    input  logic                        result_ready,
    output spmm_pkg::result_beat_t      result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spmm_pkg::AddrWidth-1:0] paddr,
    input  logic [spmm_pkg::DataWidth-1:0] pwdata,
    output logic [spmm_pkg::DataWidth-1:0] prdata,
    output logic                        pready
);
    import spmm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    value_t temp_low_reg, temp_high_reg, hum_low_reg, hum_high_reg;
    jump_t  temp_jump_reg, hum_jump_reg;
    count_t fail_lim_reg;
    logic   cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[AddrWidth-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= TempLowReset;
            temp_high_reg <= TempHighReset;
            hum_low_reg   <= HumLowReset;
            hum_high_reg  <= HumHighReset;
            temp_jump_reg <= TempJumpReset;
            hum_jump_reg  <= HumJumpReset;
            fail_lim_reg  <= FailLimReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TEMP_LOW:  temp_low_reg  <= value_t'(pwdata[ValueWidth-1:0]);
                REG_TEMP_HIGH: temp_high_reg <= value_t'(pwdata[ValueWidth-1:0]);
                REG_HUM_LOW:   hum_low_reg   <= value_t'(pwdata[ValueWidth-1:0]);
                REG_HUM_HIGH:  hum_high_reg  <= value_t'(pwdata[ValueWidth-1:0]);
                REG_TEMP_JUMP: temp_jump_reg <= pwdata[ValueWidth-1:0];
                REG_HUM_JUMP:  hum_jump_reg  <= pwdata[ValueWidth-1:0];
                REG_FAIL_LIM:  fail_lim_reg  <= pwdata[CountWidth-1:0];
                default:       ;
            endcase
        end
    end

    // Signed limits read back sign-extended, the others zero-extended.
    always_comb
    begin
        case (cfg_index)
            REG_TEMP_LOW:  prdata = DataWidth'(signed'(temp_low_reg));
            REG_TEMP_HIGH: prdata = DataWidth'(signed'(temp_high_reg));
            REG_HUM_LOW:   prdata = DataWidth'(signed'(hum_low_reg));
            REG_HUM_HIGH:  prdata = DataWidth'(signed'(hum_high_reg));
            REG_TEMP_JUMP: prdata = DataWidth'(temp_jump_reg);
            REG_HUM_JUMP:  prdata = DataWidth'(hum_jump_reg);
            REG_FAIL_LIM:  prdata = DataWidth'(fail_lim_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeding the output register
    // ------------------------------------------------------------------
    logic         stage_valid_reg;
    sample_beat_t stage_reg;
    logic         out_valid_reg;
    result_beat_t out_reg;
    logic         advance;

    // The evaluation stage moves on whenever the output register is empty
    // or is being drained in this cycle.
    assign advance      = stage_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !stage_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                stage_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            stage_reg <= sample;
        end
    end

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    value_t last_temp_reg, last_hum_reg;
    value_t hi_temp_reg, lo_temp_reg, hi_hum_reg, lo_hum_reg;
    logic   data_valid_reg;
    count_t fail_cnt_reg;

    value_t last_temp_next, last_hum_next;
    value_t hi_temp_next, lo_temp_next, hi_hum_next, lo_hum_next;
    logic   data_valid_next;
    count_t fail_cnt_next;
    status_t status;

    logic signed [ValueWidth:0] temp_diff, hum_diff;
    logic        [ValueWidth:0] temp_step, hum_step;
    logic   temp_out_of_range, hum_out_of_range;
    logic   temp_jump_bad, hum_jump_bad;
    count_t fail_inc;
    value_t t_in, h_in;

    assign t_in = stage_reg.temperature_tenths;
    assign h_in = stage_reg.humidity_tenths;

    // Inclusive range checks; crossed limits reject everything.
    assign temp_out_of_range = (t_in < temp_low_reg) || (t_in > temp_high_reg);
    assign hum_out_of_range  = (h_in < hum_low_reg)  || (h_in > hum_high_reg);

    // Magnitude of the change from the last accepted value, one bit wider
    // so that the full span of two 12-bit values fits.
    assign temp_diff = (ValueWidth+1)'(t_in) - (ValueWidth+1)'(last_temp_reg);
    assign hum_diff  = (ValueWidth+1)'(h_in) - (ValueWidth+1)'(last_hum_reg);
    assign temp_step = temp_diff[ValueWidth] ? unsigned'(-temp_diff) : unsigned'(temp_diff);
    assign hum_step  = hum_diff[ValueWidth]  ? unsigned'(-hum_diff)  : unsigned'(hum_diff);
    assign temp_jump_bad = data_valid_reg && (temp_step > {1'b0, temp_jump_reg});
    assign hum_jump_bad  = data_valid_reg && (hum_step  > {1'b0, hum_jump_reg});

    assign fail_inc = (fail_cnt_reg == CountMax) ? fail_cnt_reg : fail_cnt_reg + 1'b1;

    always_comb
    begin
        last_temp_next  = last_temp_reg;
        last_hum_next   = last_hum_reg;
        hi_temp_next    = hi_temp_reg;
        lo_temp_next    = lo_temp_reg;
        hi_hum_next     = hi_hum_reg;
        lo_hum_next     = lo_hum_reg;
        data_valid_next = data_valid_reg;
        fail_cnt_next   = fail_cnt_reg;

        // Only bit 1 of the action selects a statistics reset.
        if (stage_reg.action[1])
        begin
            status = ST_RESET;
        end
        else if (stage_reg.action == ACT_FAILED)
        begin
            status = ST_READ_FAIL;
        end
        else if (temp_out_of_range)
        begin
            status = ST_TEMP_RANGE;
        end
        else if (hum_out_of_range)
        begin
            status = ST_HUM_RANGE;
        end
        else if (temp_jump_bad)
        begin
            status = ST_TEMP_JUMP;
        end
        else if (hum_jump_bad)
        begin
            status = ST_HUM_JUMP;
        end
        else
        begin
            status = ST_ACCEPTED;
        end

        if (status == ST_RESET)
        begin
            hi_temp_next    = MostNeg;
            lo_temp_next    = MostPos;
            hi_hum_next     = MostNeg;
            lo_hum_next     = MostPos;
            data_valid_next = 1'b0;
            fail_cnt_next   = '0;
        end
        else if (status == ST_ACCEPTED)
        begin
            last_temp_next  = t_in;
            last_hum_next   = h_in;
            data_valid_next = 1'b1;
            fail_cnt_next   = '0;
            if (t_in > hi_temp_reg)
            begin
                hi_temp_next = t_in;
            end
            if (t_in < lo_temp_reg)
            begin
                lo_temp_next = t_in;
            end
            if (h_in > hi_hum_reg)
            begin
                hi_hum_next = h_in;
            end
            if (h_in < lo_hum_reg)
            begin
                lo_hum_next = h_in;
            end
        end
        else
        begin
            fail_cnt_next = fail_inc;
            if (fail_inc >= fail_lim_reg)
            begin
                data_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg  <= '0;
            last_hum_reg   <= '0;
            hi_temp_reg    <= MostNeg;
            lo_temp_reg    <= MostPos;
            hi_hum_reg     <= MostNeg;
            lo_hum_reg     <= MostPos;
            data_valid_reg <= 1'b0;
            fail_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            last_temp_reg  <= last_temp_next;
            last_hum_reg   <= last_hum_next;
            hi_temp_reg    <= hi_temp_next;
            lo_temp_reg    <= lo_temp_next;
            hi_hum_reg     <= hi_hum_next;
            lo_hum_reg     <= lo_hum_next;
            data_valid_reg <= data_valid_next;
            fail_cnt_reg   <= fail_cnt_next;
        end
    end

    // The result reports the state after the update.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.status        <= status;
            out_reg.data_valid    <= data_valid_next;
            out_reg.current_temp  <= last_temp_next;
            out_reg.current_hum   <= last_hum_next;
            out_reg.max_temp      <= hi_temp_next;
            out_reg.min_temp      <= lo_temp_next;
            out_reg.max_hum       <= hi_hum_next;
            out_reg.min_hum       <= lo_hum_next;
            out_reg.failure_count <= fail_cnt_next;
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the sensor plausibility checker
// Drives event beats through the checker under several limit settings and
// idle patterns, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import spmm_pkg::*;

    // Clock, reset and the ports of the block under test. Every input starts
    // at a known value; after time zero all of them but the clock change only
    // through nonblocking assignments at a rising edge.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_beat_t         sample_bus   = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_beat_t         result_bus;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [AddrWidth-1:0] paddr        = '0;
    logic [DataWidth-1:0] pwdata       = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    // Our copy of the limit registers, starting from their reset values.
    int cfg_temp_low  = TempLowReset;
    int cfg_temp_high = TempHighReset;
    int cfg_hum_low   = HumLowReset;
    int cfg_hum_high  = HumHighReset;
    int cfg_temp_jump = TempJumpReset;
    int cfg_hum_jump  = HumJumpReset;
    int cfg_fail_lim  = FailLimReset;

    // Our copy of the checker's state: the last accepted reading, the
    // trusted flag, the running extremes and the failure counter.
    int held_temp = 0;
    int held_hum  = 0;
    bit trusted   = 1'b0;
    int hi_temp;
    int lo_temp;
    int hi_hum;
    int lo_hum;
    int fail_tally;

    // Result beats predicted for accepted events, oldest first.
    result_beat_t awaited_results[$];

    // Percentage of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int unsigned error_count = 0;

    sensor_plausibility_minmax u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A statistics reset puts the extremes back to their empty values and
    // drops both the trust and the failure count; the held reading survives.
    function automatic void restart_statistics();
        hi_temp    = MostNeg;
        lo_temp    = MostPos;
        hi_hum     = MostNeg;
        lo_hum     = MostPos;
        fail_tally = 0;
        trusted    = 1'b0;
    endfunction

    function automatic int step_size(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Works out the result beat of one event and moves our state on. The
    // checks run in a fixed order and the first one to fail names the status;
    // all comparisons are inclusive, and the jump checks only apply while the
    // held reading is trusted.
    function automatic result_beat_t judge_event(sample_beat_t ev);
        int           t;
        int           h;
        status_t      verdict;
        result_beat_t r;
        t = signed'(ev.temperature_tenths);
        h = signed'(ev.humidity_tenths);
        // Only the upper action bit is decoded for a reset, so the spare
        // code behaves exactly like the reset code.
        if (ev.action[1])
        begin
            restart_statistics();
            verdict = ST_RESET;
        end
        else
        begin
            if (ev.action == ACT_FAILED)
                verdict = ST_READ_FAIL;
            else if (t < cfg_temp_low || t > cfg_temp_high)
                verdict = ST_TEMP_RANGE;
            else if (h < cfg_hum_low || h > cfg_hum_high)
                verdict = ST_HUM_RANGE;
            else if (trusted && step_size(t, held_temp) > cfg_temp_jump)
                verdict = ST_TEMP_JUMP;
            else if (trusted && step_size(h, held_hum) > cfg_hum_jump)
                verdict = ST_HUM_JUMP;
            else
                verdict = ST_ACCEPTED;

            if (verdict == ST_ACCEPTED)
            begin
                held_temp  = t;
                held_hum   = h;
                trusted    = 1'b1;
                fail_tally = 0;
                if (t > hi_temp) hi_temp = t;
                if (t < lo_temp) lo_temp = t;
                if (h > hi_hum) hi_hum = h;
                if (h < lo_hum) lo_hum = h;
            end
            else
            begin
                // The counter saturates; with a failure limit of zero any
                // failure withdraws the trust.
                if (fail_tally < CountMax)
                    fail_tally++;
                if (fail_tally >= cfg_fail_lim)
                    trusted = 1'b0;
            end
        end
        r.status        = verdict;
        r.data_valid    = trusted;
        r.current_temp  = value_t'(held_temp);
        r.current_hum   = value_t'(held_hum);
        r.max_temp      = value_t'(hi_temp);
        r.min_temp      = value_t'(lo_temp);
        r.max_hum       = value_t'(hi_hum);
        r.min_hum       = value_t'(lo_hum);
        r.failure_count = count_t'(fail_tally);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic sample_beat_t make_event(action_t act, int t, int h);
        sample_beat_t ev;
        ev.action             = act;
        ev.temperature_tenths = value_t'(t);
        ev.humidity_tenths    = value_t'(h);
        return ev;
    endfunction

    // Draws one value so that the checks are exercised in earnest: most often a
    // step around the held value of about the jump limit, often a value just
    // either side of a range limit, and otherwise anything at all.
    function automatic int draw_value(int held, int lo, int hi, int jump);
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 45)
            v = held + int'($urandom_range(2 * jump + 6)) - jump - 3;
        else if (sel < 70)
            v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(4)) - 2;
        else
            v = int'($urandom_range(4095)) - 2048;
        if (v < -2048) v = -2048;
        if (v > 2047) v = 2047;
        return v;
    endfunction

    function automatic sample_beat_t draw_event();
        int      sel;
        action_t act;
        sel = $urandom_range(99);
        if (sel < 80)
            act = ACT_READING;
        else if (sel < 92)
            act = ACT_FAILED;
        else if (sel < 96)
            act = ACT_RESET;
        else
            act = ACT_RESET_B;
        return make_event(act,
                          draw_value(held_temp, cfg_temp_low, cfg_temp_high, cfg_temp_jump),
                          draw_value(held_hum, cfg_hum_low, cfg_hum_high, cfg_hum_jump));
    endfunction

    // A range of plausible values, now and then with the limits crossed.
    function automatic void draw_span(output int lo, output int hi);
        int spare;
        lo = int'($urandom_range(2300)) - 2048;
        hi = lo + int'($urandom_range(2047 - lo));
        if ($urandom_range(7) == 0)
        begin
            spare = lo;
            lo    = hi;
            hi    = spare;
        end
    endfunction

    function automatic int draw_jump();
        int sel;
        sel = $urandom_range(5);
        if (sel == 0)
            return 0;
        else if (sel == 1)
            return 4095;
        else
            return $urandom_range(300, 1);
    endfunction

    // Offers one event beat and returns at the edge where it is accepted.
    // valid is only lowered when the sender decides to idle, so a beat that
    // follows straight on keeps valid high without a glitch.
    task automatic send_event(sample_beat_t ev);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        sample_bus   <= ev;
        do @(posedge clk); while (!sample_ready);
        awaited_results.push_back(judge_event(ev));
    endtask

    // Holds the sender off until every outstanding result beat has arrived.
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes all seven limit registers once the checker is idle. Writes run
    // back to back: each setup phase follows directly on the previous access
    // phase, and the bus is released after the last one.
    task automatic program_limits(int temp_low, int temp_high, int hum_low, int hum_high,
                                  int temp_jump, int hum_jump, int fail_lim);
        drain_results();
        write_limit(REG_TEMP_LOW, temp_low);
        write_limit(REG_TEMP_HIGH, temp_high);
        write_limit(REG_HUM_LOW, hum_low);
        write_limit(REG_HUM_HIGH, hum_high);
        write_limit(REG_TEMP_JUMP, temp_jump);
        write_limit(REG_HUM_JUMP, hum_jump);
        write_limit(REG_FAIL_LIM, fail_lim);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_limit(reg_index_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_TEMP_LOW:  cfg_temp_low  = signed'(value_t'(value));
            REG_TEMP_HIGH: cfg_temp_high = signed'(value_t'(value));
            REG_HUM_LOW:   cfg_hum_low   = signed'(value_t'(value));
            REG_HUM_HIGH:  cfg_hum_high  = signed'(value_t'(value));
            REG_TEMP_JUMP: cfg_temp_jump = value & 'hFFF;
            REG_HUM_JUMP:  cfg_hum_jump  = value & 'hFF_F;
            REG_FAIL_LIM:  cfg_fail_lim  = value & 'hFF;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------------

    task automatic check_field(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // Every result beat taken at an edge is compared with the oldest
    // prediction. ready for the next cycle is then drawn from the current
    // stall rate.
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat arrived with no prediction waiting");
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", want.status, result_bus.status);
                check_field("data_valid", want.data_valid, result_bus.data_valid);
                check_field("current_temp", signed'(want.current_temp),
                            signed'(result_bus.current_temp));
                check_field("current_hum", signed'(want.current_hum),
                            signed'(result_bus.current_hum));
                check_field("max_temp", signed'(want.max_temp), signed'(result_bus.max_temp));
                check_field("min_temp", signed'(want.min_temp), signed'(result_bus.min_temp));
                check_field("max_hum", signed'(want.max_hum), signed'(result_bus.max_hum));
                check_field("min_hum", signed'(want.min_hum), signed'(result_bus.min_hum));
                check_field("failure_count", want.failure_count, result_bus.failure_count);
            end
        end
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With the reset limits: a failure before any reading (extremes still
    // empty), each range limit just outside and exactly on, a reading that
    // fails both ranges, jumps exactly on and one past the limit, the trust
    // being withdrawn after three failures, and both reset codes.
    task automatic test_reset_defaults();
        send_event(make_event(ACT_FAILED, 0, 0));
        send_event(make_event(ACT_READING, -401, 500));
        send_event(make_event(ACT_READING, 1001, -1));
        send_event(make_event(ACT_READING, 500, -1));
        send_event(make_event(ACT_READING, 500, 1001));
        send_event(make_event(ACT_READING, -400, 0));
        send_event(make_event(ACT_READING, -300, 200));
        send_event(make_event(ACT_READING, -199, 200));
        send_event(make_event(ACT_READING, -300, 401));
        send_event(make_event(ACT_READING, -200, 400));
        send_event(make_event(ACT_READING, 1000, 1000));
        send_event(make_event(ACT_FAILED, 123, -456));
        send_event(make_event(ACT_FAILED, -1, -1));
        // Trust is gone, so a large step is no longer refused.
        send_event(make_event(ACT_READING, 1000, 1000));
        send_event(make_event(ACT_RESET, 0, 0));
        send_event(make_event(ACT_READING, 0, 0));
        send_event(make_event(ACT_RESET_B, $urandom_range(4095) - 2048,
                              $urandom_range(4095) - 2048));
    endtask

    // Widest limits with the full-scale step, then crossed limits with a
    // failure limit of zero, then zero jump limits with a failure limit of one.
    task automatic test_limit_extremes();
        program_limits(-2048, 2047, -2048, 2047, 4095, 4095, 255);
        send_event(make_event(ACT_READING, -2048, -2048));
        send_event(make_event(ACT_READING, 2047, 2047));
        send_event(make_event(ACT_READING, -2048, 2047));
        send_event(make_event(ACT_FAILED, 2047, -2048));

        program_limits(2047, -2048, 2047, -2048, 0, 0, 0);
        send_event(make_event(ACT_READING, 0, 0));
        send_event(make_event(ACT_READING, 2047, -2048));

        program_limits(-2048, 2047, -2048, 2047, 0, 0, 1);
        send_event(make_event(ACT_READING, 5, 5));
        send_event(make_event(ACT_READING, 5, 5));
        send_event(make_event(ACT_READING, 6, 5));
        send_event(make_event(ACT_READING, 6, 6));
        send_event(make_event(ACT_READING, 6, 7));
    endtask

    // A long run of failures drives the counter into saturation and, at the
    // largest failure limit, withdraws the trust there; one good reading
    // then clears the counter again.
    task automatic test_counter_saturation();
        program_limits(TempLowReset, TempHighReset, HumLowReset, HumHighReset,
                       TempJumpReset, HumJumpReset, 255);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        send_event(make_event(ACT_READING, 0, 500));
        repeat (260)
        begin
            if ($urandom_range(3) == 0)
                send_event(make_event(ACT_READING, 1001 + $urandom_range(1046),
                                      $urandom_range(4095) - 2048));
            else
                send_event(make_event(ACT_FAILED, $urandom_range(4095) - 2048,
                                      $urandom_range(4095) - 2048));
        end
        send_event(make_event(ACT_READING, 200, 500));
    endtask

    // Random events under each idle pattern, with fresh random limits for
    // every block of beats. Each change of limits first waits for the
    // checker to empty.
    task automatic test_random_traffic();
        int tl;
        int th;
        int hl;
        int hh;
        int fl;
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int round = 0; round < 4; round++)
            begin
                draw_span(tl, th);
                draw_span(hl, hh);
                case ($urandom_range(7))
                    0: fl = 0;
                    1: fl = 255;
                    default: fl = $urandom_range(6, 1);
                endcase
                program_limits(tl, th, hl, hh, draw_jump(), draw_jump(), fl);
                repeat (100)
                    send_event(draw_event());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        restart_statistics();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_limit_extremes();
        test_counter_saturation();
        test_random_traffic();

        // Let every result beat come back, then keep the clock running with the
        // two-stage pipe idle so that a stray beat would show up.
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
